### rtl/core/lse_pkg.sv
package lse_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      CMD_PUSH = 3'd0,
      CMD_POP  = 3'd1,
      CMD_SWAP = 3'd2,
      CMD_PEEK = 3'd3,
      CMD_DUMP = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_SHORT = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SWAP_A,
      FSM_SWAP_B,
      FSM_SWAP_C,
      FSM_PEEK,
      FSM_DUMP
   } fsm_type;

endpackage

### rtl/core/lse_ram.sv
module lse_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [lse_pkg::DATA_W-1:0]    wr_data,
   input  logic [AW-1:0]                 rd_addr,
   output logic [lse_pkg::DATA_W-1:0]    rd_data
);
   import lse_pkg::*;

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/lifo_stack_engine.sv
// Bounded LIFO stack of signed 32-bit values held in one single-port-write,
// single-port-read synchronous memory (read data registered). The block
// works on one item at a time and takes a new item only when it is idle and
// its output register is free or being emptied. Push and pop touch only the
// depth counter and the write port, so their result shows in the cycle
// after the item is accepted. Peek needs one memory read. Swap reads
// both top entries through the one read port and writes them back through
// the one write port. Dump reads one entry a cycle while the result channel
// is not stalled, top first. Errors (pop or peek on empty, swap with fewer
// than two, push on full) and an empty dump answer with the stack untouched.
// Command codes five to seven are dropped without a result. A stall on the
// result channel holds the block until the result is taken. Memory
// contents need no clearing after reset: only entries below the depth count
// are ever used.
module lifo_stack_engine #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_cmd,
   input  logic signed [lse_pkg::DATA_W-1:0]  req_operand,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [lse_pkg::DATA_W-1:0]  rsp_data_out,
   output logic                               rsp_has_data,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_last
);
   import lse_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   // FSM and counters
   fsm_type           state_ff, state_in;
   logic [CW-1:0]     depth_ff, depth_in;
   logic [AW-1:0]     cur_ff, cur_in;
   logic [DATA_W-1:0] hold_ff, hold_in;

   // output register
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic              rsp_has_ff;
   status_type        rsp_status_ff;
   logic              rsp_last_ff;

   // memory port
   logic              we;
   logic [AW-1:0]     waddr, raddr;
   logic [DATA_W-1:0] wdata, rd_data;

   // result to load
   logic              emit;
   logic [DATA_W-1:0] e_data;
   logic              e_has;
   status_type        e_status;
   logic              e_last;

   logic              can_emit, req_fire;
   logic              is_empty, is_full, is_short;
   logic [AW-1:0]     top_idx, sec_idx, push_idx;
   cmd_type           cmd;

   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == FSM_IDLE) && can_emit;
   assign req_fire  = req_valid && req_ready;
   assign cmd       = cmd_type'(req_cmd);

   assign is_empty = (depth_ff == '0);
   assign is_full  = (depth_ff >= CW'(STACK_DEPTH));
   assign is_short = (depth_ff < CW'(2));
   assign top_idx  = AW'(depth_ff - CW'(1));
   assign sec_idx  = AW'(depth_ff - CW'(2));
   assign push_idx = depth_ff[AW-1:0];

   lse_ram #(
      .DEPTH (STACK_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               case (cmd)
                  CMD_SWAP: if (!is_short) state_in = FSM_SWAP_A;
                  CMD_PEEK: if (!is_empty) state_in = FSM_PEEK;
                  CMD_DUMP: if (!is_empty) state_in = FSM_DUMP;
                  default:  state_in = FSM_IDLE;
               endcase
            end
         end
         FSM_SWAP_A: state_in = FSM_SWAP_B;
         FSM_SWAP_B: state_in = FSM_SWAP_C;
         FSM_SWAP_C: if (can_emit) state_in = FSM_IDLE;
         FSM_PEEK:   if (can_emit) state_in = FSM_IDLE;
         FSM_DUMP:   if (can_emit && (cur_ff == '0)) state_in = FSM_IDLE;
         default:    state_in = FSM_IDLE;
      endcase
   end

   // Datapath control and result build
   always_comb begin
      emit     = 1'b0;
      e_data   = '0;
      e_has    = 1'b0;
      e_status = ST_OK;
      e_last   = 1'b1;
      we       = 1'b0;
      waddr    = top_idx;
      wdata    = req_operand;
      raddr    = top_idx;
      depth_in = depth_ff;
      cur_in   = cur_ff;
      hold_in  = hold_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               case (cmd)
                  CMD_PUSH: begin
                     emit = 1'b1;
                     if (is_full) begin
                        e_status = ST_FULL;
                     end else begin
                        we       = 1'b1;
                        waddr    = push_idx;
                        depth_in = depth_ff + CW'(1);
                     end
                  end
                  CMD_POP: begin
                     emit = 1'b1;
                     if (is_empty) begin
                        e_status = ST_EMPTY;
                     end else begin
                        depth_in = depth_ff - CW'(1);
                     end
                  end
                  CMD_SWAP: begin
                     if (is_short) begin
                        emit     = 1'b1;
                        e_status = ST_SHORT;
                     end
                  end
                  CMD_PEEK: begin
                     if (is_empty) begin
                        emit     = 1'b1;
                        e_status = ST_EMPTY;
                     end
                  end
                  CMD_DUMP: begin
                     // empty dump: one ok item with no data
                     if (is_empty) begin
                        emit = 1'b1;
                     end else begin
                        cur_in = top_idx;
                     end
                  end
                  default: emit = 1'b0;
               endcase
            end
         end
         FSM_SWAP_A: begin
            // top entry arrives; hold it and fetch the one below
            hold_in = rd_data;
            raddr   = sec_idx;
         end
         FSM_SWAP_B: begin
            we    = 1'b1;
            waddr = top_idx;
            wdata = rd_data;
         end
         FSM_SWAP_C: begin
            // repeat the write while the output is stalled; harmless
            we    = 1'b1;
            waddr = sec_idx;
            wdata = hold_ff;
            emit  = can_emit;
         end
         FSM_PEEK: begin
            emit   = can_emit;
            e_data = rd_data;
            e_has  = 1'b1;
         end
         FSM_DUMP: begin
            // hold the read address on a stall, advance one entry on emit
            raddr  = cur_ff;
            e_data = rd_data;
            e_has  = 1'b1;
            e_last = (cur_ff == '0);
            if (can_emit) begin
               emit = 1'b1;
               if (cur_ff != '0) begin
                  raddr  = cur_ff - AW'(1);
                  cur_in = cur_ff - AW'(1);
               end
            end
         end
         default: emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      hold_ff <= hold_in;
      if (emit) begin
         rsp_data_ff   <= e_data;
         rsp_has_ff    <= e_has;
         rsp_status_ff <= e_status;
         rsp_last_ff   <= e_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_has_data = rsp_has_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;

   // Depth never goes past the store size
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= CW'(STACK_DEPTH))
      else $error("depth count beyond stack size");

   // Depth moves only on an accepted item
   a_depth_stable: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(depth_ff))
      else $error("depth changed without an accepted item");

   // Dump cursor stays inside the stored elements
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_DUMP) |-> ({1'b0, cur_ff} < {1'b0, depth_ff}))
      else $error("dump cursor out of range");

   // Only dump yields non-final items, and those carry data
   a_nonlast_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_has_data && (rsp_status == ST_OK)))
      else $error("non-final item without data");

endmodule
